### design/pom_pkg.sv
// ----------------------------------------------------------------------------
// pom_pkg: shared types and constants of the permutation orbit minimizer
// Transaction structs, opcodes, controller state and the command/status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
package pom_pkg;

    // Table geometry (fixed by the 6-bit vertex and index fields)
    localparam int NUM_VERTICES = 64;
    localparam int NUM_PERMS    = 64;
    localparam int VERT_W       = $clog2(NUM_VERTICES);
    localparam int PERM_W       = $clog2(NUM_PERMS);
    localparam int TAB_DEPTH    = NUM_PERMS * NUM_VERTICES;
    localparam int TAB_AW       = PERM_W + VERT_W;
    localparam int CNT_W        = 7;

    // APB register map: one 32-bit register at byte address 0
    localparam int APB_AW       = 3;
    localparam int APB_DW       = 32;

    // Register indexes and their byte addresses
    localparam int                REG_PERM_COUNT  = 0;
    localparam logic [APB_AW-1:0] ADDR_PERM_COUNT = APB_AW'(4 * REG_PERM_COUNT);

    // Opcodes
    localparam logic [2:0] OP_WRITE   = 3'd0;
    localparam logic [2:0] OP_RESTART = 3'd1;
    localparam logic [2:0] OP_FIX     = 3'd2;
    localparam logic [2:0] OP_QUERY   = 3'd3;
    localparam logic [2:0] OP_EDGE    = 3'd4;

    // Input transaction
    typedef struct packed {
        logic [2:0]        opcode;
        logic [PERM_W-1:0] perm_index;
        logic [VERT_W-1:0] vertex_a;
        logic [VERT_W-1:0] vertex_b;
    } t_in;

    // Result transaction
    typedef struct packed {
        logic              is_minimal;
        logic [VERT_W-1:0] rep_low;
        logic [VERT_W-1:0] rep_high;
        logic              set_empty;
    } t_out;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_READ,
        S_EVAL,
        S_DONE
    } t_state;

    // Controller -> datapath
    typedef struct packed {
        logic load;        // capture input transaction
        logic do_write;    // write one table entry
        logic do_restart;  // reload active mask from perm_count
        logic rd;          // issue table reads for current permutation
        logic eval;        // apply current permutation, advance index
        logic out_load;    // move result into output register
    } t_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic [2:0] op;
        logic       last;        // current permutation is the final one
        logic       pass_again;  // edge pass changed the pair, run another
        logic       out_free;    // output register can take a result
    } t_sts;

endpackage

### design/pom_ctrl.sv
// ----------------------------------------------------------------------------
// pom_ctrl: operation sequencer
// Accepts one transaction at a time, dispatches on the opcode and walks
// the permutations with a read / evaluate step pair per permutation.
// ----------------------------------------------------------------------------
module pom_ctrl import pom_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_ready
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_sts.op)
                    OP_WRITE: begin
                        o_cmd.do_write = 1'b1;
                        n_state        = S_DONE;
                    end
                    OP_RESTART: begin
                        o_cmd.do_restart = 1'b1;
                        n_state          = S_DONE;
                    end
                    OP_FIX, OP_QUERY, OP_EDGE: begin
                        n_state = S_READ;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                // last permutation ends the walk unless the edge pass moved
                if (i_sts.last && !i_sts.pass_again) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_READ;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### design/pom_dp.sv
// ----------------------------------------------------------------------------
// pom_dp: permutation table, active mask and evaluation datapath
// Holds the 4096-entry image table, the active mask, the working pair
// and the output register.
// ----------------------------------------------------------------------------
module pom_dp import pom_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_in              i_in,
    input  logic [CNT_W-1:0] i_perm_count,
    input  t_cmd             i_cmd,
    input  logic             i_out_stall,
    output t_sts             o_sts,
    output t_out             o_out,
    output logic             o_out_valid
);

    // Image table
    logic [VERT_W-1:0] r_tab [0:TAB_DEPTH-1];

    // Captured transaction and working registers
    logic [2:0]           r_op;
    logic [PERM_W-1:0]    r_pi;
    logic [VERT_W-1:0]    r_vb;
    logic [VERT_W-1:0]    r_s;
    logic [VERT_W-1:0]    r_t;
    logic [PERM_W-1:0]    r_p;
    logic                 r_changed;
    logic                 r_min;
    logic [NUM_PERMS-1:0] r_mask;
    logic [VERT_W-1:0]    r_img_s;
    logic [VERT_W-1:0]    r_img_t;
    t_out                 r_out;
    logic                 r_out_valid;

    logic act;
    logic lowers;
    logic cur_change;

    // Table write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.do_write) begin
            r_tab[{r_pi, r_s}] <= r_vb;
        end
    end

    // Table read ports: images of both working vertices
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_img_s <= r_tab[{r_p, r_s}];
            r_img_t <= r_tab[{r_p, r_t}];
        end
    end

    // Current permutation test
    assign act        = r_mask[r_p];
    assign lowers     = (r_img_s < r_s) || ((r_img_s == r_s) && (r_img_t < r_t));
    assign cur_change = (r_op == OP_EDGE) && act && lowers;

    // Working pair, permutation index, pass and query flags
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= i_in.opcode;
            r_pi      <= i_in.perm_index;
            r_vb      <= i_in.vertex_b;
            r_p       <= '0;
            r_changed <= 1'b0;
            r_min     <= 1'b1;
            // edge endpoints go smaller first
            if ((i_in.opcode == OP_EDGE) && (i_in.vertex_b < i_in.vertex_a)) begin
                r_s <= i_in.vertex_b;
                r_t <= i_in.vertex_a;
            end else begin
                r_s <= i_in.vertex_a;
                r_t <= i_in.vertex_b;
            end
        end else if (i_cmd.eval) begin
            r_p <= r_p + 1'b1;
            if (o_sts.last) begin
                r_changed <= 1'b0;
            end else begin
                r_changed <= r_changed | cur_change;
            end
            if (cur_change) begin
                r_s <= r_img_s;
                r_t <= r_img_t;
            end
            if ((r_op == OP_QUERY) && act && (r_img_s < r_s)) begin
                r_min <= 1'b0;
            end
        end
    end

    // Active mask: restart and stabilizer pruning
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (i_cmd.do_restart) begin
            for (int p = 0; p < NUM_PERMS; p++) begin
                r_mask[p] <= (CNT_W'(p) < i_perm_count);
            end
        end else if (i_cmd.eval && (r_op == OP_FIX) && act && (r_img_s != r_s)) begin
            r_mask[r_p] <= 1'b0;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.is_minimal <= (r_op == OP_QUERY) && r_min;
            r_out.rep_low    <= (r_op == OP_EDGE) ? r_s : '0;
            r_out.rep_high   <= (r_op == OP_EDGE) ? r_t : '0;
            r_out.set_empty  <= ~|r_mask;
        end
    end

    // Status to the controller
    always_comb begin
        o_sts.op         = r_op;
        o_sts.last       = (r_p == PERM_W'(NUM_PERMS - 1));
        o_sts.pass_again = r_changed | cur_change;
        o_sts.out_free   = !r_out_valid || !i_out_stall;
    end

    assign o_out       = r_out;
    assign o_out_valid = r_out_valid;

endmodule

### design/permutation_orbit_minimizer.sv
// ----------------------------------------------------------------------------
// permutation_orbit_minimizer: stabilizer chain and orbit minimizer
// Permutation table with active mask; write, restart, fix, minimality
// query and edge orbit representative, one result per transaction.
// ----------------------------------------------------------------------------
// One transaction is in progress at a time. A table write, a restart or an
// unused opcode goes from dispatch straight to the result stage. Fix and
// minimality query walk all 64 permutations, each with a table read and
// then an evaluate step. Edge reduction repeats that walk until a pass
// leaves the pair unchanged, counting the final unchanged pass, so at
// least two passes run when anything moves. The walk's length is set by
// the table's registered read and the dependence of each permutation on
// the previous pair. Output stalls hold the block only while a finished
// result finds the output register still occupied. A finished result
// waits in the output register while the next transaction is accepted.
// perm_count is written over APB at address 0.
module permutation_orbit_minimizer import pom_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in               i_in,
    // output channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out              o_out,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    t_cmd             cmd;
    t_sts             sts;
    logic             ready;
    logic [CNT_W-1:0] r_perm_count;
    logic             reg_sel;

    // Register decode on the word address
    assign reg_sel = (paddr[APB_AW-1:2] == 1'(REG_PERM_COUNT));
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_perm_count <= '0;
        end else if (psel && penable && pwrite && reg_sel) begin
            r_perm_count <= pwdata[CNT_W-1:0];
        end
    end

    assign prdata = reg_sel ? {{(APB_DW-CNT_W){1'b0}}, r_perm_count} : '0;

    assign o_in_stall = !ready;

    pom_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_ready    (ready)
    );

    pom_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_perm_count (r_perm_count),
        .i_cmd        (cmd),
        .i_out_stall  (i_out_stall),
        .o_sts        (sts),
        .o_out        (o_out),
        .o_out_valid  (o_out_valid)
    );

    // An accepted transaction blocks the input until its result is in the output register
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accepting a transaction");

    // A result never overwrites one still waiting to be taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> !(o_out_valid && i_out_stall))
        else $error("result overwrote a pending result");

    // Query and edge results are exclusive
    a_field_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.is_minimal) |-> (o_out.rep_low == '0 && o_out.rep_high == '0))
        else $error("minimality result carries an edge representative");

    // Table walk runs only while a transaction is held
    a_walk_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.rd || cmd.eval) |-> o_in_stall)
        else $error("table walk while input is open");

endmodule

### test/pom_orbit_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pom_orbit_checker: result predictor and scoreboard for the orbit minimizer
// Watches the input, output and APB channels of the block, keeps a private
// copy of the permutation table, the active set and perm_count, works out
// the result of every accepted transaction and compares it field by field.
// ----------------------------------------------------------------------------
module pom_orbit_checker import pom_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input channel
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  t_in               i_in,
    // output channel
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  t_out              i_out,
    // configuration port
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic              i_pready,
    input  logic [APB_AW-1:0] i_paddr,
    input  logic [APB_DW-1:0] i_pwdata,
    // run statistics
    output int                o_fail_count,
    output int                o_pending,
    output int                o_checked,
    output int                o_moved_edges,
    output int                o_empty_results
);

    localparam int MAX_REPORTS = 10;

    // Shadow of the block state
    logic [VERT_W-1:0] perm_img [NUM_PERMS][NUM_VERTICES];
    logic [NUM_PERMS-1:0] live_perms;
    logic [CNT_W-1:0]     restart_count;

    // Results still owed by the block, oldest first
    t_out owed_results [$];

    // Apply one transaction to the shadow state and return its result
    function automatic t_out apply_op(input t_in item);
        t_out              res;
        logic [VERT_W-1:0] s, t, ns, nt;
        logic              moved;
        int                p;
        res = '0;
        case (item.opcode)
            OP_WRITE: begin
                perm_img[item.perm_index][item.vertex_a] = item.vertex_b;
            end
            OP_RESTART: begin
                for (p = 0; p < NUM_PERMS; p++)
                    live_perms[p] = (p < int'(restart_count));
            end
            OP_FIX: begin
                for (p = 0; p < NUM_PERMS; p++)
                    if (live_perms[p] && perm_img[p][item.vertex_a] != item.vertex_a)
                        live_perms[p] = 1'b0;
            end
            OP_QUERY: begin
                res.is_minimal = 1'b1;
                for (p = 0; p < NUM_PERMS; p++)
                    if (live_perms[p] && perm_img[p][item.vertex_a] < item.vertex_a)
                        res.is_minimal = 1'b0;
            end
            OP_EDGE: begin
                // order the endpoints, then greedy passes until stable
                s = (item.vertex_b < item.vertex_a) ? item.vertex_b : item.vertex_a;
                t = (item.vertex_b < item.vertex_a) ? item.vertex_a : item.vertex_b;
                do begin
                    moved = 1'b0;
                    for (p = 0; p < NUM_PERMS; p++) begin
                        if (live_perms[p]) begin
                            ns = perm_img[p][s];
                            nt = perm_img[p][t];
                            if (ns < s || (ns == s && nt < t)) begin
                                s     = ns;
                                t     = nt;
                                moved = 1'b1;
                            end
                        end
                    end
                end while (moved);
                if (s != ((item.vertex_b < item.vertex_a) ? item.vertex_b : item.vertex_a))
                    o_moved_edges++;
                else if (t != ((item.vertex_b < item.vertex_a) ? item.vertex_a
                                                               : item.vertex_b))
                    o_moved_edges++;
                res.rep_low  = s;
                res.rep_high = t;
            end
            default: ;  // spare opcodes leave the state alone
        endcase
        res.set_empty = (live_perms == '0);
        return res;
    endfunction

    // Channel monitor: APB write, then input, then output at each edge
    always @(posedge i_clk) begin : monitor
        t_out owed;
        if (!i_rst_n) begin
            live_perms    = '0;
            restart_count = '0;
            owed_results.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == ADDR_PERM_COUNT)
                restart_count = i_pwdata[CNT_W-1:0];

            if (i_in_valid && !i_in_stall)
                owed_results.insert(owed_results.size(), apply_op(i_in));

            if (i_out_valid && !i_out_stall) begin
                if (owed_results.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= MAX_REPORTS)
                        $display("%0t: unexpected result %p with nothing outstanding",
                                 $realtime, i_out);
                end else begin
                    owed = owed_results.pop_front();
                    o_checked++;
                    if (owed.set_empty)
                        o_empty_results++;
                    if (i_out.is_minimal !== owed.is_minimal ||
                        i_out.rep_low    !== owed.rep_low    ||
                        i_out.rep_high   !== owed.rep_high   ||
                        i_out.set_empty  !== owed.set_empty) begin
                        o_fail_count++;
                        if (o_fail_count <= MAX_REPORTS)
                            $display({"%0t: result mismatch  expected min=%0b lo=%0d hi=%0d",
                                      " empty=%0b  got min=%0b lo=%0d hi=%0d empty=%0b"},
                                     $realtime, owed.is_minimal, owed.rep_low,
                                     owed.rep_high, owed.set_empty, i_out.is_minimal,
                                     i_out.rep_low, i_out.rep_high, i_out.set_empty);
                    end
                end
            end
        end
        o_pending = owed_results.size();
    end

endmodule

### test/tb_permutation_orbit_minimizer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_permutation_orbit_minimizer: self-checking bench for the orbit minimizer
// Loads the first rows of the permutation table, runs directed corner
// transactions, then random stabilizer-chain sequences (restart, fixes,
// queries, edge reductions) mixed with noise, over several perm_count
// settings. Random gaps and output stalls; results are checked by
// pom_orbit_checker.
// ----------------------------------------------------------------------------
module tb_permutation_orbit_minimizer;
    import pom_pkg::*;

    localparam int                CLK_PERIOD      = 10;
    localparam int                RESET_CYCLES    = 6;
    localparam int                ITEMS_PER_PHASE = 90;
    // rows loaded in full; perm_count stays at or below this whenever the
    // active set is walked
    localparam int                LOAD_ROWS       = 6;
    // A reduction may in theory need one pass per lower pair (4096); the
    // watchdog allows several times that many passes.
    localparam int                STALL_LIMIT     = 2_500_000;
    localparam int                SETTLE_CYCLES   = 300;
    // opcodes the block does not use
    localparam logic [2:0]        OP_SPARE5       = 3'd5;
    localparam logic [2:0]        OP_SPARE6       = 3'd6;
    localparam logic [2:0]        OP_SPARE7       = 3'd7;

    logic              i_clk;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_stall;
    t_in               i_in        = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    t_out              o_out;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [APB_AW-1:0] paddr       = '0;
    logic [APB_DW-1:0] pwdata      = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    int fail_count, pending, checked, moved_edges, empty_results;

    logic              calm = 1'b1;     // no gaps, no stalls while set
    int                items_sent = 0;
    int                idle_cycles = 0;
    int                stall_hold = 0;
    int                n_fill, n_directed, n_settings = 0;
    logic [VERT_W-1:0] perm_buf [NUM_VERTICES];

    permutation_orbit_minimizer DUT (.*);

    pom_orbit_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_in            (i_in),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_out           (o_out),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_pready        (pready),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked),
        .o_moved_edges   (moved_edges),
        .o_empty_results (empty_results)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Output back-pressure: runs of ready and stall, mostly short
    always @(posedge i_clk) begin
        if (!i_rst_n || calm) begin
            i_out_stall <= 1'b0;
            stall_hold  <= 0;
        end else if (stall_hold > 0) begin
            stall_hold <= stall_hold - 1;
        end else begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    i_out_stall <= 1'b0;
                    stall_hold  <= $urandom_range(1, 6);
                end
                9: begin
                    i_out_stall <= 1'b1;
                    stall_hold  <= $urandom_range(10, 40);
                end
                default: begin
                    i_out_stall <= 1'b1;
                    stall_hold  <= $urandom_range(1, 4);
                end
            endcase
        end
    end

    // Watchdog on cycles without any accepted transaction or taken result
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm)    return 0;
        if (r < 55)  return 0;
        if (r < 90)  return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_in mk(input logic [2:0] op, input logic [PERM_W-1:0] pi,
                               input logic [VERT_W-1:0] a, input logic [VERT_W-1:0] b);
        t_in item;
        item.opcode     = op;
        item.perm_index = pi;
        item.vertex_a   = a;
        item.vertex_b   = b;
        return item;
    endfunction

    function automatic logic [VERT_W-1:0] any_vertex();
        return VERT_W'($urandom_range(0, NUM_VERTICES - 1));
    endfunction

    // Present one transaction, hold it until taken, then maybe idle
    task automatic push_item(input t_in item);
        int gap;
        i_in       <= item;
        i_in_valid <= 1'b1;
        do @(negedge i_clk); while (o_in_stall);
        @(posedge i_clk);
        items_sent++;
        gap = pick_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drop valid and wait until every owed result has come back
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (8) @(posedge i_clk);
    endtask

    // APB write of perm_count: setup, then access until pready
    task automatic set_perm_count(input int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_PERM_COUNT;
        pwdata  <= APB_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(negedge i_clk); while (!pready);
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        n_settings++;
        repeat (2) @(posedge i_clk);
    endtask

    // Build one table row: identity, a few swaps, block rotations or a shuffle
    task automatic build_perm(input int idx);
        int v, w, k, base, rot;
        logic [VERT_W-1:0] tmp;
        for (v = 0; v < NUM_VERTICES; v++)
            perm_buf[v] = VERT_W'(v);
        if (idx != 0) begin
            case ($urandom_range(0, 3))
                0, 1: begin
                    repeat ($urandom_range(1, 4)) begin
                        v = $urandom_range(0, NUM_VERTICES - 1);
                        w = $urandom_range(0, NUM_VERTICES - 1);
                        tmp = perm_buf[v];
                        perm_buf[v] = perm_buf[w];
                        perm_buf[w] = tmp;
                    end
                end
                2: begin
                    for (base = 0; base < NUM_VERTICES; base += 8) begin
                        if ($urandom_range(0, 1) == 1) begin
                            rot = $urandom_range(1, 7);
                            for (k = 0; k < 8; k++)
                                perm_buf[base + k] = VERT_W'(base + (k + rot) % 8);
                        end
                    end
                end
                default: begin
                    for (v = NUM_VERTICES - 1; v > 0; v--) begin
                        w = $urandom_range(0, v);
                        tmp = perm_buf[v];
                        perm_buf[v] = perm_buf[w];
                        perm_buf[w] = tmp;
                    end
                end
            endcase
        end
    endtask

    // Query or edge reduction with random filler in the unused fields
    task automatic probe();
        if ($urandom_range(0, 1) == 0)
            push_item(mk(OP_QUERY, PERM_W'($urandom), any_vertex(), any_vertex()));
        else
            push_item(mk(OP_EDGE, PERM_W'($urandom), any_vertex(), any_vertex()));
    endtask

    // One random phase: stabilizer chains with some noise in between
    task automatic random_phase(input int unsigned count_value);
        int target;
        int r;
        drain();
        set_perm_count(count_value);
        target = items_sent + ITEMS_PER_PHASE;
        calm   = 1'b1;
        while (items_sent < target) begin
            if (items_sent > target - ITEMS_PER_PHASE + 25)
                calm = 1'b0;
            r = $urandom_range(0, 99);
            if (r < 12) begin
                case ($urandom_range(0, 3))
                    0: push_item(mk(OP_WRITE, PERM_W'($urandom), any_vertex(), any_vertex()));
                    1: push_item(mk(3'($urandom_range(OP_SPARE5, OP_SPARE7)),
                                    PERM_W'($urandom), any_vertex(), any_vertex()));
                    2: push_item(mk(OP_FIX, PERM_W'($urandom), any_vertex(), any_vertex()));
                    default: probe();
                endcase
            end else begin
                push_item(mk(OP_RESTART, PERM_W'($urandom), any_vertex(), any_vertex()));
                repeat ($urandom_range(0, 4)) begin
                    push_item(mk(OP_FIX, PERM_W'($urandom), any_vertex(), any_vertex()));
                    repeat ($urandom_range(1, 3)) probe();
                end
                if ($urandom_range(0, 1) == 1)
                    probe();
            end
        end
    endtask

    // Stimulus
    initial begin : stimulus
        int p, v, n_random_start;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // load every entry of the rows that are ever walked
        set_perm_count(0);
        for (p = 0; p < LOAD_ROWS; p++) begin
            build_perm(p);
            calm = (p % 4 != 0);
            for (v = 0; v < NUM_VERTICES; v++)
                push_item(mk(OP_WRITE, PERM_W'(p), VERT_W'(v), perm_buf[v]));
        end
        n_fill = items_sent;

        // directed: empty set with perm_count zero
        calm = 1'b0;
        push_item(mk(OP_RESTART, '0, '0, '0));
        push_item(mk(OP_QUERY, '0, '1, '0));
        push_item(mk(OP_EDGE, '0, '1, '0));
        push_item(mk(OP_SPARE5, '1, '1, '1));
        push_item(mk(OP_FIX, '0, '0, '0));

        // directed: oversized perm_count, only operations that walk nothing
        drain();
        set_perm_count(127);
        push_item(mk(OP_RESTART, '1, '1, '1));
        push_item(mk(OP_SPARE6, '0, '0, '0));
        push_item(mk(OP_SPARE7, '1, '1, '1));

        // directed: extremes of each field over the loaded rows
        drain();
        set_perm_count(LOAD_ROWS);
        push_item(mk(OP_RESTART, '1, '1, '1));
        push_item(mk(OP_QUERY, '0, '0, '0));
        push_item(mk(OP_QUERY, '0, '1, '0));
        push_item(mk(OP_EDGE, '0, '0, '0));
        push_item(mk(OP_EDGE, '0, '1, '1));
        push_item(mk(OP_EDGE, '0, '1, '0));
        push_item(mk(OP_EDGE, '0, VERT_W'(5), VERT_W'(3)));
        // table no longer a permutation in two rows
        push_item(mk(OP_WRITE, PERM_W'(LOAD_ROWS - 1), '1, '0));
        push_item(mk(OP_WRITE, '0, '0, '1));
        push_item(mk(OP_EDGE, '0, '1, VERT_W'(62)));
        push_item(mk(OP_QUERY, '0, '1, '0));
        push_item(mk(OP_FIX, '0, '0, '0));
        push_item(mk(OP_FIX, '1, '1, '1));
        push_item(mk(OP_QUERY, '0, '1, '0));
        push_item(mk(OP_EDGE, '0, '1, VERT_W'(62)));
        push_item(mk(OP_RESTART, '0, '0, '0));
        n_directed = items_sent - n_fill;

        // random phases over several perm_count settings
        n_random_start = items_sent;
        random_phase(LOAD_ROWS);
        random_phase(1);
        random_phase($urandom_range(2, LOAD_ROWS - 1));
        random_phase($urandom_range(0, LOAD_ROWS));

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("run: %0d table loads, %0d directed, %0d random, %0d perm_count writes",
                 n_fill, n_directed, items_sent - n_random_start, n_settings);
        $display("run: %0d results checked, %0d edges reduced, %0d reported an empty set",
                 checked, moved_edges, empty_results);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("failures: %0d, results still owed: %0d", fail_count, pending);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### filelist.f
design/pom_pkg.sv
design/pom_ctrl.sv
design/pom_dp.sv
design/permutation_orbit_minimizer.sv
test/pom_orbit_checker.sv
test/tb_permutation_orbit_minimizer.sv
